@@ hdl/rc5_block_cipher_assert.svh @@
`ifndef RC5_BLOCK_CIPHER_ASSERT_SVH
`define RC5_BLOCK_CIPHER_ASSERT_SVH

// Implication checked in the same cycle, switched off while reset is held.
`define RC5_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, switched off while reset is held.
`define RC5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rc5_pkg.sv @@
package rc5_pkg;

    // Magic constants of the key schedule for 32-bit words.
    localparam logic [31:0] RC5_P32 = 32'hB7E15163;
    localparam logic [31:0] RC5_Q32 = 32'h9E3779B9;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_cfg_data;
    typedef logic [1:0]  t_cfg_idx;
    typedef logic [4:0]  t_key_len;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_KEY_LOW    = 2'd0;
    localparam t_cfg_idx CFG_KEY_HIGH   = 2'd1;
    localparam t_cfg_idx CFG_KEY_LENGTH = 2'd2;

    localparam t_key_len KEY_LEN_RESET = 5'd16;

    // Sequencer of the cipher.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPAND = 4'b0010,
        S_LOAD   = 4'b0100,
        S_RUN    = 4'b1000
    } t_state;

    // Sequencer of the key expansion.
    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_INIT  = 5'b00010,
        E_PRIME = 5'b00100,
        E_MIXA  = 5'b01000,
        E_MIXB  = 5'b10000
    } t_exp_state;

    // Rotate left by the low five bits of the amount.
    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    // Rotate right by the low five bits of the amount.
    function automatic t_word rotr(input t_word x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

endpackage

@@ hdl/rc5_block_cipher.sv @@
// An accepted start passes through S_LOAD and the S_RUN steps 0 to ROUNDS; o_valid is
// registered from the last step. The first block after a key write first runs the key
// expansion in S_EXPAND, over SUBKEYS = 2 * (ROUNDS+1) subkeys.
// A new block is taken only while idle, once the previous block is done; one round per cycle.
// Reset clears the sequencers, sets the key to zero with length 16 and marks the schedule
// pending; the subkey memory is not cleared. Results cannot be stalled by the receiver.
`include "rc5_block_cipher_assert.svh"

module rc5_block_cipher #(
    parameter int ROUNDS = 12,
    parameter int KEY_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  rc5_pkg::t_cfg_idx   i_cfg_idx,
    input  rc5_pkg::t_cfg_data  i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic                i_mode,
    input  rc5_pkg::t_word      i_in_a,
    input  rc5_pkg::t_word      i_in_b,
    output logic                o_valid,
    output rc5_pkg::t_word      o_out_a,
    output rc5_pkg::t_word      o_out_b
);
    import rc5_pkg::*;

    localparam int SUBKEYS = 2 * (ROUNDS + 1);
    localparam int SK_AW   = $clog2(SUBKEYS);
    localparam int STEP_W  = $clog2(ROUNDS + 2);

    t_state             r_state;
    logic               r_ready;
    t_cfg_data          r_key_low;
    t_cfg_data          r_key_high;
    t_key_len           r_key_len;
    logic               r_mode;
    t_word              r_a;
    t_word              r_b;
    logic [STEP_W-1:0]  r_step;

    logic               accept;
    logic               cfg_key;
    logic               exp_start;
    logic               exp_done;
    logic               exp_we;
    logic [SK_AW-1:0]   exp_waddr;
    t_word              exp_wdata;
    logic [SK_AW-1:0]   exp_raddr;
    logic               ram_we;
    logic [SK_AW-1:0]   ram_raddr0;
    logic [SK_AW-1:0]   dp_raddr0;
    logic [SK_AW-1:0]   dp_raddr1;
    t_word              sk0;
    t_word              sk1;
    logic [STEP_W-1:0]  rd_step;
    logic [STEP_W-1:0]  rd_k;
    logic [STEP_W-1:0]  k_eff;
    logic               step_first;
    logic               step_last;
    t_word              t_mid;
    t_word              n_a;
    t_word              n_b;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign exp_start = accept && !r_ready;
    assign cfg_key   = i_cfg_we && (i_cfg_idx == CFG_KEY_LOW || i_cfg_idx == CFG_KEY_HIGH
                                    || i_cfg_idx == CFG_KEY_LENGTH);

    rc5_key_expand #(
        .ROUNDS    (ROUNDS),
        .KEY_BYTES (KEY_BYTES)
    ) u_expand (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (exp_start),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_key_len  (r_key_len),
        .i_sk_rdata (sk0),
        .o_sk_we    (exp_we),
        .o_sk_waddr (exp_waddr),
        .o_sk_wdata (exp_wdata),
        .o_sk_raddr (exp_raddr),
        .o_done     (exp_done)
    );

    // The expansion engine owns the write port and read port 0 while it runs.
    assign ram_we     = (r_state == S_EXPAND) && exp_we;
    assign ram_raddr0 = (r_state == S_EXPAND) ? exp_raddr : dp_raddr0;

    rc5_sk_ram #(
        .DEPTH (SUBKEYS)
    ) u_sk_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (exp_waddr),
        .i_wdata  (exp_wdata),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (dp_raddr1),
        .o_rdata0 (sk0),
        .o_rdata1 (sk1)
    );

    // Subkey pair for the next step: ascending for encryption, descending for decryption.
    assign rd_step   = (r_state == S_RUN) ? r_step + STEP_W'(1) : '0;
    assign rd_k      = (rd_step > STEP_W'(ROUNDS)) ? '0 : rd_step;
    assign k_eff     = r_mode ? STEP_W'(ROUNDS) - rd_k : rd_k;
    assign dp_raddr0 = {k_eff[SK_AW-2:0], 1'b0};
    assign dp_raddr1 = {k_eff[SK_AW-2:0], 1'b1};

    // One round per step, with the key whitening on the first or last step.
    assign step_first = (r_step == '0);
    assign step_last  = (r_step == STEP_W'(ROUNDS));

    always_comb begin
        t_mid = '0;
        if (!r_mode) begin
            if (step_first) begin
                n_a = r_a + sk0;
                n_b = r_b + sk1;
            end else begin
                t_mid = rotl(r_a ^ r_b, r_b[4:0]) + sk0;
                n_a   = t_mid;
                n_b   = rotl(r_b ^ t_mid, t_mid[4:0]) + sk1;
            end
        end else begin
            if (step_last) begin
                n_b = r_b - sk1;
                n_a = r_a - sk0;
            end else begin
                t_mid = rotr(r_b - sk1, r_a[4:0]) ^ r_a;
                n_b   = t_mid;
                n_a   = rotr(r_a - sk0, t_mid[4:0]) ^ t_mid;
            end
        end
    end

    // Control: sequencer, schedule flag, key registers and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ready    <= 1'b0;
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_RESET;
            r_step     <= '0;
            o_valid    <= 1'b0;
        end else begin
            // The result beat is registered from the last step, so it comes in the cycle after it.
            o_valid <= (r_state == S_RUN) && step_last;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= r_ready ? S_LOAD : S_EXPAND;
                    end
                end
                S_EXPAND: begin
                    if (exp_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_RUN;
                    r_step  <= '0;
                end
                S_RUN: begin
                    if (step_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A key write wins over a finishing expansion.
            if (cfg_key || exp_done) begin
                r_ready <= !cfg_key;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY_LOW:    r_key_low  <= i_cfg_data;
                    CFG_KEY_HIGH:   r_key_high <= i_cfg_data;
                    CFG_KEY_LENGTH: r_key_len  <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Block words and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_a    <= i_in_a;
            r_b    <= i_in_b;
        end else if (r_state == S_RUN) begin
            r_a <= n_a;
            r_b <= n_b;
        end
        if (r_state == S_RUN && step_last) begin
            o_out_a <= n_a;
            o_out_b <= n_b;
        end
    end

    // Checks on the sequencing.
    `RC5_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy,
        "accepted beat did not make the block busy")
    `RC5_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy,
        "result beat while the block is still busy")
    `RC5_ASSERT_NEXT(a_key_write_pending, i_clk, i_rst_n, cfg_key, !r_ready,
        "key write did not mark the schedule pending")
    `RC5_ASSERT_NOW(a_done_in_expand, i_clk, i_rst_n, exp_done, r_state == S_EXPAND,
        "key expansion finished outside the expansion state")

endmodule

@@ hdl/rc5_sk_ram.sv @@
module rc5_sk_ram #(
    parameter int DEPTH = 26,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rc5_pkg::t_word  i_wdata,
    input  logic [AW-1:0]   i_raddr0,
    input  logic [AW-1:0]   i_raddr1,
    output rc5_pkg::t_word  o_rdata0,
    output rc5_pkg::t_word  o_rdata1
);
    import rc5_pkg::*;

    t_word mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

@@ hdl/rc5_key_expand.sv @@
module rc5_key_expand #(
    parameter int ROUNDS = 12,
    parameter int KEY_BYTES = 16,
    localparam int SUBKEYS = 2 * (ROUNDS + 1),
    localparam int SK_AW = $clog2(SUBKEYS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rc5_pkg::t_cfg_data  i_key_low,
    input  rc5_pkg::t_cfg_data  i_key_high,
    input  rc5_pkg::t_key_len   i_key_len,
    input  rc5_pkg::t_word      i_sk_rdata,
    output logic                o_sk_we,
    output logic [SK_AW-1:0]    o_sk_waddr,
    output rc5_pkg::t_word      o_sk_wdata,
    output logic [SK_AW-1:0]    o_sk_raddr,
    output logic                o_done
);
    import rc5_pkg::*;

    localparam int KW_DEPTH = (KEY_BYTES + 3) / 4;
    localparam int KW_AW    = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1;
    localparam int KWC_W    = $clog2(KW_DEPTH + 1);
    localparam int INIT_N   = (SUBKEYS > KW_DEPTH) ? SUBKEYS : KW_DEPTH;
    localparam int INIT_W   = $clog2(INIT_N);
    localparam int MIX_W    = $clog2(3 * INIT_N);

    t_word lmem [KW_DEPTH];

    t_exp_state         r_state;
    logic [INIT_W-1:0]  r_cnt;
    t_word              r_sv;
    logic [SK_AW-1:0]   r_si;
    logic [KW_AW-1:0]   r_kj;
    logic [MIX_W-1:0]   r_iter;
    t_word              r_a;
    t_word              r_b;
    t_word              r_ab;
    t_word              r_l;
    t_word              r_ldata;
    logic               r_fwd;

    logic [127:0]       key_all;
    logic [5:0]         len_sat;
    logic [KWC_W-1:0]   words_raw;
    logic [KWC_W-1:0]   words;
    logic [MIX_W-1:0]   mix_last;
    logic [SK_AW-1:0]   n_si;
    logic [KW_AW-1:0]   n_kj;
    logic [5:0]         byte_idx;
    t_word              l_fill;
    t_word              l_cur;
    t_word              a_new;
    t_word              b_new;
    logic               in_init;
    logic               l_we;
    logic [KW_AW-1:0]   l_waddr;
    t_word              l_wdata;
    logic [KW_AW-1:0]   l_raddr;

    // Key length saturates to the key store; an empty key still uses one word.
    assign key_all   = {i_key_high, i_key_low};
    assign len_sat   = (6'(i_key_len) > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : 6'(i_key_len);
    assign words_raw = KWC_W'((7'(len_sat) + 7'd3) >> 2);
    assign words     = (words_raw == '0) ? KWC_W'(1) : words_raw;

    // The mixing pass runs three times over the larger of the two tables.
    always_comb begin
        if (SUBKEYS >= int'(words)) begin
            mix_last = MIX_W'(3 * SUBKEYS - 1);
        end else begin
            mix_last = MIX_W'(3 * int'(words) - 1);
        end
    end

    assign n_si = (r_si == SK_AW'(SUBKEYS - 1)) ? '0 : r_si + SK_AW'(1);
    assign n_kj = ((KWC_W'(r_kj) + KWC_W'(1)) == words) ? '0 : r_kj + KW_AW'(1);

    // Key word for the fill pass: bytes past the length or past byte 15 read as zero.
    always_comb begin
        l_fill   = '0;
        byte_idx = '0;
        for (int b = 0; b < 4; b++) begin
            byte_idx = 6'({r_cnt[KW_AW-1:0], 2'(b)});
            if (byte_idx < len_sat && byte_idx < 6'd16) begin
                l_fill[8*b +: 8] = key_all[{byte_idx[3:0], 3'b000} +: 8];
            end
        end
    end

    // Mixing arithmetic, split over the E_MIXA and E_MIXB states of each step.
    assign l_cur = r_fwd ? r_b : r_ldata;
    assign a_new = rotl(i_sk_rdata + r_a + r_b, 5'd3);
    assign b_new = rotl(r_l + r_ab, r_ab[4:0]);

    // Subkey memory access.
    assign in_init    = (r_state == E_INIT);
    assign o_sk_we    = (in_init && ({1'b0, r_cnt} < (INIT_W + 1)'(SUBKEYS)))
                        || (r_state == E_MIXA);
    assign o_sk_waddr = in_init ? r_cnt[SK_AW-1:0] : r_si;
    assign o_sk_wdata = in_init ? r_sv : a_new;
    assign o_sk_raddr = (r_state == E_MIXB) ? n_si : r_si;
    assign o_done     = (r_state == E_MIXB) && (r_iter == mix_last);

    // Key word memory access.
    assign l_we    = (in_init && ({1'b0, r_cnt} < (INIT_W + 1)'(KW_DEPTH)))
                     || (r_state == E_MIXB);
    assign l_waddr = in_init ? r_cnt[KW_AW-1:0] : r_kj;
    assign l_wdata = in_init ? l_fill : b_new;
    assign l_raddr = (r_state == E_MIXB) ? n_kj : r_kj;

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            lmem[l_waddr] <= l_wdata;
        end
        r_ldata <= lmem[l_raddr];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_state <= E_INIT;
                    end
                end
                E_INIT: begin
                    if (r_cnt == INIT_W'(INIT_N - 1)) begin
                        r_state <= E_PRIME;
                    end
                end
                E_PRIME: begin
                    r_state <= E_MIXA;
                end
                E_MIXA: begin
                    r_state <= E_MIXB;
                end
                E_MIXB: begin
                    r_state <= (r_iter == mix_last) ? E_IDLE : E_MIXA;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    // Counters and working words.
    always_ff @(posedge i_clk) begin
        if (r_state == E_IDLE && i_start) begin
            r_cnt  <= '0;
            r_sv   <= RC5_P32;
            r_si   <= '0;
            r_kj   <= '0;
            r_iter <= '0;
            r_a    <= '0;
            r_b    <= '0;
            r_fwd  <= 1'b0;
        end
        if (in_init) begin
            r_cnt <= r_cnt + INIT_W'(1);
            r_sv  <= r_sv + RC5_Q32;
        end
        if (r_state == E_MIXA) begin
            r_a  <= a_new;
            r_ab <= a_new + r_b;
            r_l  <= l_cur;
        end
        // A single key word is reread while being written, so it is forwarded.
        if (r_state == E_MIXB) begin
            r_b    <= b_new;
            r_si   <= n_si;
            r_kj   <= n_kj;
            r_iter <= r_iter + MIX_W'(1);
            r_fwd  <= (n_kj == r_kj);
        end
    end

endmodule

@@ test/tb_rc5_block_cipher.sv @@
module tb_rc5_block_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import rc5_pkg::*;

    localparam int ROUNDS         = 12;
    localparam int KEY_BYTES      = 16;
    localparam int SUBKEY_COUNT   = 2 * (ROUNDS + 1);
    localparam int KEY_WORD_DEPTH = (KEY_BYTES + 3) / 4;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_COUNT    = 4;

    localparam bit MODE_ENCRYPT = 1'b0;
    localparam bit MODE_DECRYPT = 1'b1;

    // Index 3 is not a register; writes to it must leave the key alone.
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_word a;
        t_word b;
    } cipher_block_t;

    // Holds a copy of the key registers and the subkey schedule, works out the
    // cipher output of every accepted beat and compares it with the results.
    class cipher_scoreboard;
        t_cfg_data     key_lo;
        t_cfg_data     key_hi;
        t_key_len      key_len;
        t_word         subkeys [SUBKEY_COUNT];
        bit            schedule_ready;
        cipher_block_t expected_blocks [$];
        cipher_block_t last_block;
        int unsigned   mismatches;

        function new();
            key_lo         = '0;
            key_hi         = '0;
            key_len        = KEY_LEN_RESET;
            schedule_ready = 1'b0;
            last_block     = '0;
            mismatches     = 0;
        endfunction

        static function t_word rot_left(t_word x, logic [4:0] n);
            if (n == 5'd0)
                return x;
            return (x << n) | (x >> (6'd32 - n));
        endfunction

        static function t_word rot_right(t_word x, logic [4:0] n);
            if (n == 5'd0)
                return x;
            return (x >> n) | (x << (6'd32 - n));
        endfunction

        // Bytes past the two key registers read as zero.
        function logic [7:0] key_byte(int unsigned idx);
            if (idx < 8)
                return key_lo[8 * idx +: 8];
            if (idx < 16)
                return key_hi[8 * (idx - 8) +: 8];
            return 8'h00;
        endfunction

        // Standard key expansion; an empty key still uses one zero key word.
        function void expand_schedule();
            int unsigned len;
            int unsigned words;
            int unsigned passes;
            int unsigned i;
            int unsigned j;
            t_word       kw [KEY_WORD_DEPTH];
            t_word       a;
            t_word       b;
            t_word       sum;
            len = int'(key_len);
            if (len > KEY_BYTES)
                len = KEY_BYTES;
            words = (len + 3) / 4;
            if (words == 0)
                words = 1;
            foreach (kw[k])
                kw[k] = '0;
            for (int k = len; k > 0; k--)
                kw[(k - 1) / 4] = (kw[(k - 1) / 4] << 8) + t_word'(key_byte(k - 1));

            subkeys[0] = RC5_P32;
            for (int k = 1; k < SUBKEY_COUNT; k++)
                subkeys[k] = subkeys[k - 1] + RC5_Q32;

            passes = 3 * ((SUBKEY_COUNT > words) ? SUBKEY_COUNT : words);
            a = '0;
            b = '0;
            i = 0;
            j = 0;
            for (int k = 0; k < passes; k++) begin
                subkeys[i] = rot_left(subkeys[i] + a + b, 5'd3);
                a = subkeys[i];
                sum = a + b;
                kw[j] = rot_left(kw[j] + a + b, sum[4:0]);
                b = kw[j];
                i = (i + 1) % SUBKEY_COUNT;
                j = (j + 1) % words;
            end
            schedule_ready = 1'b1;
        endfunction

        function cipher_block_t cipher_block(bit mode, t_word a_in, t_word b_in);
            t_word         a;
            t_word         b;
            cipher_block_t res;
            if (!schedule_ready)
                expand_schedule();
            a = a_in;
            b = b_in;
            if (mode == MODE_ENCRYPT) begin
                a = a + subkeys[0];
                b = b + subkeys[1];
                for (int r = 1; r <= ROUNDS; r++) begin
                    a = rot_left(a ^ b, b[4:0]) + subkeys[2 * r];
                    b = rot_left(b ^ a, a[4:0]) + subkeys[2 * r + 1];
                end
            end else begin
                for (int r = ROUNDS; r >= 1; r--) begin
                    b = rot_right(b - subkeys[2 * r + 1], a[4:0]) ^ a;
                    a = rot_right(a - subkeys[2 * r], b[4:0]) ^ b;
                end
                b = b - subkeys[1];
                a = a - subkeys[0];
            end
            res.a = a;
            res.b = b;
            return res;
        endfunction

        // Any write to a real register, even of the same value, forces a new expansion.
        function void write_register(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_KEY_LOW:    key_lo = data;
                CFG_KEY_HIGH:   key_hi = data;
                CFG_KEY_LENGTH: key_len = data[4:0];
                default:        return;
            endcase
            schedule_ready = 1'b0;
        endfunction

        function void note_block(bit mode, t_word a, t_word b);
            last_block = cipher_block(mode, a, b);
            expected_blocks.push_back(last_block);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_block(t_word a, t_word b);
            cipher_block_t want;
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("result %h %h with no block outstanding", a, b));
                return;
            end
            want = expected_blocks.pop_front();
            if (a !== want.a)
                report_mismatch($sformatf("out_a got %h, want %h", a, want.a));
            if (b !== want.b)
                report_mismatch($sformatf("out_b got %h, want %h", b, want.b));
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    t_cfg_idx    i_cfg_idx  = CFG_KEY_LOW;
    t_cfg_data   i_cfg_data = '0;
    logic        start      = 1'b0;
    logic        busy;
    logic        i_mode     = MODE_ENCRYPT;
    t_word       i_in_a     = '0;
    t_word       i_in_b     = '0;
    logic        o_valid;
    t_word       o_out_a;
    t_word       o_out_b;
    int unsigned cycles     = 0;

    cipher_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    rc5_block_cipher #(
        .ROUNDS    (ROUNDS),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_mode     (i_mode),
        .i_in_a     (i_in_a),
        .i_in_b     (i_in_b),
        .o_valid    (o_valid),
        .o_out_a    (o_out_a),
        .o_out_b    (o_out_b)
    );

    // Results cannot be held off, so every strobed cycle is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_block(o_out_a, o_out_b);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(31);
            3:       return ~(t_word'(1) << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cfg_data pick_dword();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one beat and holds it until the block takes it.
    task automatic send_block(bit mode, t_word a, t_word b);
        start  <= 1'b1;
        i_mode <= mode;
        i_in_a <= a;
        i_in_b <= b;
        do @(posedge i_clk); while (busy);
        sb.note_block(mode, a, b);
    endtask

    // Random idle cycles on the sending side, now and then a long one.
    task automatic sender_gap(int unsigned pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
            if ($urandom_range(15) == 0)
                repeat ($urandom_range(30)) @(posedge i_clk);
        end
    endtask

    // Stops sending until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.expected_blocks.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // New key while idle; lengths are mostly legal, sometimes empty or oversized.
    task automatic load_random_key();
        logic [4:0] len;
        t_cfg_data  upper;
        wait_drained();
        if ($urandom_range(3) != 0)
            write_reg(CFG_KEY_LOW, pick_dword());
        if ($urandom_range(3) != 0)
            write_reg(CFG_KEY_HIGH, pick_dword());
        case ($urandom_range(7))
            0:       len = 5'd0;
            1:       len = 5'($urandom_range(31, 17));
            2:       len = 5'd16;
            default: len = 5'($urandom_range(16, 1));
        endcase
        upper = ($urandom_range(1) == 0) ? '0 : {$urandom, $urandom};
        write_reg(CFG_KEY_LENGTH, {upper[63:5], len});
        if ($urandom_range(7) == 0)
            write_reg(CFG_UNUSED, pick_dword());
    endtask

    // Random blocks; some decrypt the latest predicted result, a round trip when it was an encryption.
    task automatic random_blocks(int unsigned count, int unsigned idle_pct);
        bit    mode;
        t_word a;
        t_word b;
        repeat (count) begin
            if ($urandom_range(4) == 0) begin
                mode = MODE_DECRYPT;
                a    = sb.last_block.a;
                b    = sb.last_block.b;
            end else begin
                mode = 1'($urandom_range(1));
                a    = pick_word();
                b    = pick_word();
            end
            sender_gap(idle_pct);
            send_block(mode, a, b);
            if ($urandom_range(59) == 0)
                wait_drained();
        end
    endtask

    initial begin
        int unsigned idle_pcts [PHASE_COUNT];

        idle_pcts = '{0, 75, 0, 31};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key: all-zero bytes, full length. Word extremes both ways.
        send_block(MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(MODE_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(MODE_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(MODE_DECRYPT, sb.last_block.a, sb.last_block.b);

        // All-ones key at full length.
        wait_drained();
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LENGTH, t_cfg_data'(16));
        send_block(MODE_ENCRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_block(MODE_DECRYPT, sb.last_block.a, sb.last_block.b);

        // Empty key.
        wait_drained();
        write_reg(CFG_KEY_LENGTH, t_cfg_data'(0));
        send_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);

        // Single key byte.
        wait_drained();
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_KEY_LENGTH, t_cfg_data'(1));
        send_block(MODE_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);

        // Oversized lengths saturate to the full key; upper data bits are ignored.
        wait_drained();
        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LENGTH, '1);
        send_block(MODE_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_block(MODE_DECRYPT, sb.last_block.a, sb.last_block.b);
        wait_drained();
        write_reg(CFG_KEY_LENGTH, t_cfg_data'(17));
        send_block(MODE_ENCRYPT, 32'h7FFF_FFFF, 32'h8000_0000);

        // Write to the unused index, then a rewrite of an unchanged value.
        wait_drained();
        write_reg(CFG_UNUSED, '1);
        send_block(MODE_ENCRYPT, 32'h1111_1111, 32'h2222_2222);
        wait_drained();
        write_reg(CFG_KEY_HIGH, sb.key_hi);
        send_block(MODE_DECRYPT, 32'h3333_3333, 32'h4444_4444);

        // Random part, one idling pattern per phase, several keys in each.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            repeat (4) begin
                load_random_key();
                random_blocks(44, idle_pcts[p]);
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_blocks.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ rc5_block_cipher.f @@
+incdir+hdl
hdl/rc5_pkg.sv
hdl/rc5_sk_ram.sv
hdl/rc5_key_expand.sv
hdl/rc5_block_cipher.sv
test/tb_rc5_block_cipher.sv
